// ----- hw/rtl/dgb_pkg.sv -----
// Shared constants and types for the depth-of-field row gather blur.
package dgb_pkg;

   localparam int MaxRadius  = 16;
   localparam int WinDepth   = 2 * MaxRadius + 1;
   localparam int IdxBits    = 6;
   localparam int PosBits    = 12;
   localparam int LineLast   = 4095;
   localparam int ColorMax   = 65535;
   localparam int OneQ16     = 65536;
   localparam int RadHalf    = 8;
   localparam int DivNumBits = 38;
   localparam int DivDenBits = 22;
   localparam int DivCntBits = 6;
   localparam int TSteps     = 25;
   localparam int FinSteps   = 38;

   // Configuration register indexes
   localparam logic [1:0] CsrWindowRadius = 2'd0;
   localparam logic [1:0] CsrOpaqueMode   = 2'd1;
   localparam logic [1:0] CsrEmitStart    = 2'd2;
   localparam logic [1:0] CsrEmitEnd      = 2'd3;

   typedef struct packed {
      logic                    start;
      logic [DivNumBits-1:0]   num;
      logic [DivDenBits-1:0]   den;
      logic [DivCntBits-1:0]   steps;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic [DivNumBits-1:0]   quot;
   } div_rsp_type;

endpackage

// ----- hw/rtl/dgb_div.sv -----
// Restoring divider, one quotient bit per cycle, numerator aligned to the top.
module dgb_div (
   input  logic                 clock,
   input  logic                 reset,
   input  dgb_pkg::div_req_type req,
   output dgb_pkg::div_rsp_type rsp
);

   logic [dgb_pkg::DivNumBits-1:0] num_ff;
   logic [dgb_pkg::DivNumBits-1:0] quo_ff;
   logic [dgb_pkg::DivDenBits-1:0] rem_ff;
   logic [dgb_pkg::DivDenBits-1:0] den_ff;
   logic [dgb_pkg::DivCntBits-1:0] cnt_ff;
   logic                           busy_ff;
   logic                           done_ff;

   logic [dgb_pkg::DivDenBits:0]   trial;
   logic [dgb_pkg::DivDenBits:0]   diff;
   logic                           ge;

   // Shift in the next numerator bit and try the subtract
   always_comb begin
      trial = {rem_ff, num_ff[dgb_pkg::DivNumBits-1]};
      ge    = trial >= {1'b0, den_ff};
      diff  = trial - {1'b0, den_ff};
   end

   // Track the busy window and flag completion
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= req.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == dgb_pkg::DivCntBits'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Advance the partial remainder and quotient
   always_ff @(posedge clock) begin
      if (req.start) begin
         num_ff <= req.num;
         den_ff <= req.den;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[dgb_pkg::DivNumBits-2:0], 1'b0};
         rem_ff <= ge ? diff[dgb_pkg::DivDenBits-1:0] : trial[dgb_pkg::DivDenBits-1:0];
         quo_ff <= {quo_ff[dgb_pkg::DivNumBits-2:0], ge};
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule

// ----- hw/rtl/dof_row_gather_blur.sv -----
// Top level of the horizontal variable-radius depth-of-field gather blur.
//
// Pixels of one image line enter on the req_ channel (RGBA Q0.16, signed Q6.4
// radius, line_end marker); blurred pixels leave on the rsp_ channel. The result
// for position x leaves once pixel x+R has arrived, or when the line ends, so
// a line end may release up to R+1 results. Results outside the emit range are
// skipped: they are neither computed nor sent.
// Each item is handled to completion before the next is taken: req_stall is
// high while results are computed or wait on the rsp_ side. One result gathers
// N neighbors, N = neighbors in the window (up to 2R+1); opaque mode adds an
// alpha-weighting step (ST_OPQ) per neighbor, and a neighbor with a negative or
// sub-half-pixel radius skips the divider. The one-bit-per-cycle divider runs
// 25 steps per neighbor distance ratio and 38 steps per channel normalization.
// An in-focus center pixel is copied without a gather. When rsp_stall is high,
// the result is held unchanged.
// Reset restores the register defaults (radius 8, emit range 0..4096) and
// starts a fresh line; the pixel window needs no clearing.
// Configuration writes on the csr_ channel are always ready and must be made
// only while the block is idle.
module dof_row_gather_blur (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_red,
   input  logic [15:0]        req_green,
   input  logic [15:0]        req_blue,
   input  logic [15:0]        req_alpha,
   input  logic signed [10:0] req_radius,
   input  logic               req_line_end,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_out_red,
   output logic [15:0]        rsp_out_green,
   output logic [15:0]        rsp_out_blue,
   output logic [15:0]        rsp_out_alpha,
   output logic               rsp_out_line_end,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [12:0]        csr_wdata
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CHECK = 4'd1;
   localparam logic [3:0] ST_CRD   = 4'd2;
   localparam logic [3:0] ST_CCHK  = 4'd3;
   localparam logic [3:0] ST_NRD   = 4'd4;
   localparam logic [3:0] ST_NWGT  = 4'd5;
   localparam logic [3:0] ST_DIVT  = 4'd6;
   localparam logic [3:0] ST_MUL2  = 4'd7;
   localparam logic [3:0] ST_SKW   = 4'd8;
   localparam logic [3:0] ST_KW    = 4'd9;
   localparam logic [3:0] ST_OPQ   = 4'd10;
   localparam logic [3:0] ST_ACC   = 4'd11;
   localparam logic [3:0] ST_FIN   = 4'd12;
   localparam logic [3:0] ST_FDIV  = 4'd13;
   localparam logic [3:0] ST_OUT   = 4'd14;

   localparam int IB = dgb_pkg::IdxBits;
   localparam int PB = dgb_pkg::PosBits;

   // Configuration
   logic [4:0]  win_rad_ff;
   logic        opaque_ff;
   logic [11:0] emit_start_ff;
   logic [12:0] emit_end_ff;

   // Line control
   logic [3:0]    state_ff;
   logic [PB-1:0] pos_ff;
   logic [IB-1:0] wptr_ff;
   logic [4:0]    pend_ff;
   logic [PB-1:0] x_ff;
   logic [IB-1:0] xidx_ff;
   logic [PB-1:0] cur_p_ff;
   logic          last_ff;
   logic [4:0]    r_ff;
   logic          mark_ff;
   logic [PB-1:0] k_ff;
   logic [IB-1:0] kidx_ff;
   logic [PB-1:0] hi_ff;
   logic [1:0]    ch_ff;

   // Datapath
   logic [74:0]   win_mem [dgb_pkg::WinDepth];
   logic [74:0]   rdata_ff;
   logic [63:0]   cen_ff;
   logic [63:0]   px_ff;
   logic [16:0]   t_ff;
   logic [33:0]   tt_ff;
   logic [51:0]   s_ff;
   logic [16:0]   kw_ff;
   logic [33:0]   prod_ff;
   logic [16:0]   w_ff;
   logic [37:0]   sum_ff [4];
   logic [21:0]   total_ff;
   logic [15:0]   out_ff [4];

   dgb_pkg::div_req_type div_req;
   dgb_pkg::div_rsp_type div_rsp;

   logic          accept;
   logic [4:0]    r_eff;
   logic          cond;
   logic          in_range;
   logic [12:0]   nx;
   logic [12:0]   first_nx;
   logic          more;
   logic [PB-1:0] lo;
   logic [4:0]    lo_diff;
   logic [IB-1:0] lo_idx;
   logic [12:0]   x_plus_r;
   logic [PB-1:0] hi;
   logic [IB-1:0] xidx_inc;
   logic [IB-1:0] kidx_inc;
   logic [IB-1:0] wptr_inc;
   logic [IB-1:0] rd_addr;
   logic [4:0]    nbr_dist;
   logic [10:0]   nrad;
   logic [24:0]   tnum;
   logic [16:0]   t_clamp;
   logic [52:0]   s_round;
   logic [20:0]   s16;
   logic [16:0]   s16_cap;
   logic [17:0]   opq_q;
   logic [18:0]   opq_rem;
   logic [15:0]   cur_chan;
   logic [15:0]   cen_chan;
   logic          infocus;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = state_ff == ST_OUT;

   // Window position and loop bookkeeping
   always_comb begin
      r_eff    = (win_rad_ff > 5'(dgb_pkg::MaxRadius)) ? 5'(dgb_pkg::MaxRadius) : win_rad_ff;
      x_plus_r = {1'b0, x_ff} + 13'(r_ff);
      cond     = (pend_ff != 5'd0) && (last_ff || (x_plus_r <= {1'b0, cur_p_ff}));
      in_range = (x_ff >= emit_start_ff) && ({1'b0, x_ff} < emit_end_ff);
      nx       = {1'b0, x_ff} + 13'd1;
      first_nx = (nx > {1'b0, emit_start_ff}) ? nx : {1'b0, emit_start_ff};
      more     = (first_nx <= {1'b0, cur_p_ff}) && (first_nx < emit_end_ff);
      if (x_ff >= PB'(r_ff)) begin
         lo      = x_ff - PB'(r_ff);
         lo_diff = r_ff;
      end else begin
         lo      = '0;
         lo_diff = x_ff[4:0];
      end
      lo_idx   = (xidx_ff >= IB'(lo_diff)) ? xidx_ff - IB'(lo_diff)
                                           : xidx_ff + IB'(dgb_pkg::WinDepth) - IB'(lo_diff);
      hi       = (x_plus_r < {1'b0, cur_p_ff}) ? x_plus_r[PB-1:0] : cur_p_ff;
      xidx_inc = (xidx_ff == IB'(dgb_pkg::WinDepth - 1)) ? '0 : xidx_ff + 1'b1;
      kidx_inc = (kidx_ff == IB'(dgb_pkg::WinDepth - 1)) ? '0 : kidx_ff + 1'b1;
      wptr_inc = (wptr_ff == IB'(dgb_pkg::WinDepth - 1)) ? '0 : wptr_ff + 1'b1;
      rd_addr  = (state_ff == ST_CRD) ? xidx_ff : kidx_ff;
   end

   // Neighbor weight arithmetic
   always_comb begin
      nrad     = rdata_ff[74:64];
      nbr_dist = (k_ff > x_ff) ? 5'(k_ff - x_ff) : 5'(x_ff - k_ff);
      tnum     = (25'(nbr_dist) << 20) + 25'(nrad[9:1]);
      t_clamp  = (div_rsp.quot > 38'(dgb_pkg::OneQ16)) ? 17'(dgb_pkg::OneQ16)
                                                      : div_rsp.quot[16:0];
      s_round  = {1'b0, s_ff} + 53'(64'h8000_0000);
      s16      = s_round[52:32];
      s16_cap  = (s16 > 21'(dgb_pkg::OneQ16)) ? 17'(dgb_pkg::OneQ16) : s16[16:0];
      opq_q    = prod_ff[33:16];
      opq_rem  = 19'(prod_ff[15:0]) + 19'(opq_q);
      for (int i = 0; i < 3; i++) begin
         if (opq_rem >= 19'(dgb_pkg::ColorMax)) begin
            opq_rem = opq_rem - 19'(dgb_pkg::ColorMax);
            opq_q   = opq_q + 1'b1;
         end
      end
      cur_chan = px_ff[16*ch_ff +: 16];
      cen_chan = cen_ff[16*ch_ff +: 16];
      infocus  = !opaque_ff && (rdata_ff[63:48] != 16'd0) && !rdata_ff[74]
                 && (rdata_ff[73:64] < 10'(dgb_pkg::RadHalf));
   end

   // Start the shared divider
   always_comb begin
      div_req = '0;
      if (state_ff == ST_NWGT && !nrad[10] && nrad[9:0] >= 10'(dgb_pkg::RadHalf)) begin
         div_req.start = 1'b1;
         div_req.num   = {tnum, 13'd0};
         div_req.den   = 22'(nrad[9:0]);
         div_req.steps = 6'(dgb_pkg::TSteps);
      end else if (state_ff == ST_FIN && total_ff != 22'd0) begin
         div_req.start = 1'b1;
         div_req.num   = sum_ff[ch_ff] + 38'(total_ff[21:1]);
         div_req.den   = total_ff;
         div_req.steps = 6'(dgb_pkg::FinSteps);
      end
   end

   dgb_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Write arriving pixels, read one entry per cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         win_mem[wptr_ff] <= {req_radius, req_alpha, req_blue, req_green, req_red};
      end
      rdata_ff <= win_mem[rd_addr];
   end

   // Take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         win_rad_ff    <= 5'd8;
         opaque_ff     <= 1'b0;
         emit_start_ff <= '0;
         emit_end_ff   <= 13'd4096;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dgb_pkg::CsrWindowRadius: win_rad_ff    <= csr_wdata[4:0];
            dgb_pkg::CsrOpaqueMode:   opaque_ff     <= csr_wdata[0];
            dgb_pkg::CsrEmitStart:    emit_start_ff <= csr_wdata[11:0];
            dgb_pkg::CsrEmitEnd:      emit_end_ff   <= csr_wdata;
         endcase
      end
   end

   // Sequence the line and the per-result gather
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         wptr_ff  <= '0;
         pend_ff  <= '0;
         x_ff     <= '0;
         xidx_ff  <= '0;
         last_ff  <= 1'b0;
         ch_ff    <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cur_p_ff <= pos_ff;
                  last_ff  <= req_line_end || (pos_ff == PB'(dgb_pkg::LineLast));
                  r_ff     <= r_eff;
                  pend_ff  <= pend_ff + 1'b1;
                  if (req_line_end || (pos_ff == PB'(dgb_pkg::LineLast))) begin
                     pos_ff  <= '0;
                     wptr_ff <= '0;
                  end else begin
                     pos_ff  <= pos_ff + 1'b1;
                     wptr_ff <= wptr_inc;
                  end
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (cond && in_range) begin
                  mark_ff  <= last_ff && !more;
                  k_ff     <= lo;
                  kidx_ff  <= lo_idx;
                  hi_ff    <= hi;
                  state_ff <= ST_CRD;
               end else if (cond) begin
                  x_ff    <= x_ff + 1'b1;
                  xidx_ff <= xidx_inc;
                  pend_ff <= pend_ff - 1'b1;
               end else begin
                  if (last_ff) begin
                     x_ff    <= '0;
                     xidx_ff <= '0;
                     pend_ff <= '0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            ST_CRD: state_ff <= ST_CCHK;
            ST_CCHK: begin
               cen_ff <= rdata_ff[63:0];
               if (infocus) begin
                  for (int c = 0; c < 4; c++) out_ff[c] <= rdata_ff[16*c +: 16];
                  state_ff <= ST_OUT;
               end else begin
                  for (int c = 0; c < 4; c++) sum_ff[c] <= '0;
                  total_ff <= '0;
                  state_ff <= ST_NRD;
               end
            end
            ST_NRD: state_ff <= ST_NWGT;
            ST_NWGT: begin
               px_ff <= rdata_ff[63:0];
               ch_ff <= '0;
               if (nrad[10]) begin
                  kw_ff    <= '0;
                  state_ff <= ST_KW;
               end else if (nrad[9:0] < 10'(dgb_pkg::RadHalf)) begin
                  kw_ff    <= (nbr_dist == 5'd0) ? 17'(dgb_pkg::OneQ16) : 17'd0;
                  state_ff <= ST_KW;
               end else begin
                  state_ff <= ST_DIVT;
               end
            end
            ST_DIVT: begin
               if (div_rsp.done) begin
                  t_ff     <= t_clamp;
                  tt_ff    <= 34'(t_clamp) * 34'(t_clamp);
                  state_ff <= ST_MUL2;
               end
            end
            ST_MUL2: begin
               s_ff     <= 52'(tt_ff) * 52'(18'd196608 - {t_ff, 1'b0});
               state_ff <= ST_SKW;
            end
            ST_SKW: begin
               kw_ff    <= 17'(dgb_pkg::OneQ16) - s16_cap;
               state_ff <= ST_KW;
            end
            ST_KW: begin
               if (opaque_ff) begin
                  prod_ff  <= 34'(kw_ff) * 34'(px_ff[63:48]) + 34'd32767;
                  state_ff <= ST_OPQ;
               end else begin
                  w_ff     <= kw_ff;
                  state_ff <= ST_ACC;
               end
            end
            ST_OPQ: begin
               w_ff     <= opq_q[16:0];
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               sum_ff[ch_ff] <= sum_ff[ch_ff] + 38'(w_ff) * 38'(cur_chan);
               ch_ff         <= ch_ff + 1'b1;
               if (ch_ff == 2'd3) begin
                  total_ff <= total_ff + 22'(w_ff);
                  if (k_ff == hi_ff) begin
                     state_ff <= ST_FIN;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     kidx_ff  <= kidx_inc;
                     state_ff <= ST_NRD;
                  end
               end
            end
            ST_FIN: begin
               if (total_ff == 22'd0) begin
                  out_ff[ch_ff] <= cen_chan;
                  ch_ff         <= ch_ff + 1'b1;
                  if (ch_ff == 2'd3) state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_FDIV;
               end
            end
            ST_FDIV: begin
               if (div_rsp.done) begin
                  out_ff[ch_ff] <= (div_rsp.quot > 38'(dgb_pkg::ColorMax))
                                   ? 16'(dgb_pkg::ColorMax) : div_rsp.quot[15:0];
                  ch_ff         <= ch_ff + 1'b1;
                  state_ff      <= (ch_ff == 2'd3) ? ST_OUT : ST_FIN;
               end
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  x_ff     <= x_ff + 1'b1;
                  xidx_ff  <= xidx_inc;
                  pend_ff  <= pend_ff - 1'b1;
                  state_ff <= ST_CHECK;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_out_red      = out_ff[0];
   assign rsp_out_green    = out_ff[1];
   assign rsp_out_blue     = out_ff[2];
   assign rsp_out_alpha    = out_ff[3];
   assign rsp_out_line_end = mark_ff;

endmodule
